[src/lcgrb_pkg.sv]
`default_nettype none

package lcgrb_pkg;

  typedef enum logic [2:0] {
    CMD_BYTE         = 3'd0,
    CMD_BYTE_LIMITED = 3'd1,
    CMD_WORD         = 3'd2,
    CMD_WORD_LIMITED = 3'd3,
    CMD_WHEEL_INDEX  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW,
    ST_EVAL,
    ST_SCALE_MUL,
    ST_SCALE_TAKE,
    ST_DONE
  } state_e;

  localparam logic [15:0] MulConst     = 16'd2053;
  localparam logic [15:0] AddConst     = 16'd13849;
  localparam logic [7:0]  WheelSpan    = 8'd255;
  localparam logic [7:0]  WheelMinDist = 8'd42;

  // operands for the shared multiply-add unit
  typedef struct packed {
    logic        en;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
  } mac_req_t;

endpackage

`default_nettype wire

[src/lcgrb_mac.sv]
`default_nettype none

module lcgrb_mac (
  input  wire logic                clk_i,
  input  wire lcgrb_pkg::mac_req_t req_i,
  output logic [31:0]              p_o
);

  logic [31:0] prod;
  logic [31:0] sum;
  logic [31:0] p_q;

  assign prod = {16'h0000, req_i.a} * {16'h0000, req_i.b};
  // cannot overflow: 65535*65535 + 65535 < 2**32
  assign sum  = prod + {16'h0000, req_i.c};

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      p_q <= sum;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[src/lcg_random_byte_unit.sv]
// lcg_random_byte_unit: random values from a 16-bit linear congruential
// generator (seed = seed*2053 + 13849, byte = low byte of seed + high byte).
// Input channel s_axis carries one request: command, limit and wheel
// position. Output channel m_axis returns exactly one 16-bit value for each
// request, in order. Commands: byte, byte scaled by limit, word (first draw
// is the high byte), word scaled by limit, and wheel index (draws repeat
// until the byte is at least 42 steps from the position on a 255 wheel).
// All multiplications run through one registered 16x16 multiply-add unit
// under a small sequencer, so the block takes one request at a time. Unused
// command codes skip the draw and return value 0. The block is ready for the
// next request in the same cycle that the result turns valid. Each draw is a
// multiply-add step followed by an evaluate step; each scaling adds a
// multiply step and a take step. A finished result sits in an output
// register; the next request is taken while it waits, and a stalled receiver
// only holds the sequencer in its final step until the register frees. Reset
// clears the seed to zero and empties the output register.
`default_nettype none

module lcg_random_byte_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [2:0] command, [18:3] limit, [26:19] position, [31:27] zero
  input  wire logic [31:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [15:0] value
  output logic [15:0]      m_axis_tdata_o
);

  lcgrb_pkg::state_e   state_q, state_d;
  logic [2:0]          cmd_q, cmd_d;
  logic [15:0]         lim_q, lim_d;
  logic [7:0]          pos_q, pos_d;
  logic [15:0]         seed_q, seed_d;
  logic [7:0]          hi_q, hi_d;
  logic                half_q, half_d;
  logic [15:0]         res_q, res_d;
  logic                out_valid_q, out_valid_d;
  logic [15:0]         out_data_q, out_data_d;
  logic                out_load;

  lcgrb_pkg::mac_req_t mac_req;
  logic [31:0]         mac_p;
  logic [7:0]          draw_b;
  logic [7:0]          dist_x;
  logic [7:0]          dist_y;
  logic [7:0]          wheel_dist;
  logic                is_byte_lim;

  lcgrb_mac u_mac (
    .clk_i (clk_i),
    .req_i (mac_req),
    .p_o   (mac_p)
  );

  assign draw_b      = mac_p[7:0] + mac_p[15:8];
  assign dist_x      = (pos_q >= draw_b) ? (pos_q - draw_b) : (draw_b - pos_q);
  assign dist_y      = lcgrb_pkg::WheelSpan - dist_x;
  assign wheel_dist  = (dist_x < dist_y) ? dist_x : dist_y;
  assign is_byte_lim = (cmd_q == lcgrb_pkg::CMD_BYTE_LIMITED);

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    lim_d    = lim_q;
    pos_d    = pos_q;
    seed_d   = seed_q;
    hi_d     = hi_q;
    half_d   = half_q;
    res_d    = res_q;
    out_load = 1'b0;
    mac_req  = '{en: 1'b0, a: seed_q, b: lcgrb_pkg::MulConst, c: lcgrb_pkg::AddConst};

    case (state_q)
      lcgrb_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d  = s_axis_tdata_i[2:0];
          lim_d  = s_axis_tdata_i[18:3];
          pos_d  = s_axis_tdata_i[26:19];
          half_d = 1'b0;
          if (s_axis_tdata_i[2:0] inside {lcgrb_pkg::CMD_BYTE, lcgrb_pkg::CMD_BYTE_LIMITED,
                                          lcgrb_pkg::CMD_WORD, lcgrb_pkg::CMD_WORD_LIMITED,
                                          lcgrb_pkg::CMD_WHEEL_INDEX}) begin
            state_d = lcgrb_pkg::ST_DRAW;
          end else begin
            // unused code: no draw, value zero
            res_d   = 16'h0000;
            state_d = lcgrb_pkg::ST_DONE;
          end
        end
      end
      lcgrb_pkg::ST_DRAW: begin
        mac_req.en = 1'b1;
        state_d    = lcgrb_pkg::ST_EVAL;
      end
      lcgrb_pkg::ST_EVAL: begin
        seed_d = mac_p[15:0];
        case (cmd_q)
          lcgrb_pkg::CMD_BYTE: begin
            res_d   = {8'h00, draw_b};
            state_d = lcgrb_pkg::ST_DONE;
          end
          lcgrb_pkg::CMD_BYTE_LIMITED: begin
            res_d   = {8'h00, draw_b};
            state_d = lcgrb_pkg::ST_SCALE_MUL;
          end
          lcgrb_pkg::CMD_WORD, lcgrb_pkg::CMD_WORD_LIMITED: begin
            if (!half_q) begin
              hi_d    = draw_b;
              half_d  = 1'b1;
              state_d = lcgrb_pkg::ST_DRAW;
            end else begin
              res_d   = {hi_q, draw_b};
              state_d = (cmd_q == lcgrb_pkg::CMD_WORD) ? lcgrb_pkg::ST_DONE
                                                       : lcgrb_pkg::ST_SCALE_MUL;
            end
          end
          lcgrb_pkg::CMD_WHEEL_INDEX: begin
            // full-period generator: a qualifying byte always turns up
            if (wheel_dist >= lcgrb_pkg::WheelMinDist) begin
              res_d   = {8'h00, draw_b};
              state_d = lcgrb_pkg::ST_DONE;
            end else begin
              state_d = lcgrb_pkg::ST_DRAW;
            end
          end
          default: begin
            res_d   = 16'h0000;
            state_d = lcgrb_pkg::ST_DONE;
          end
        endcase
      end
      lcgrb_pkg::ST_SCALE_MUL: begin
        mac_req = '{en: 1'b1, a: res_q,
                    b: is_byte_lim ? {8'h00, lim_q[7:0]} : lim_q, c: 16'h0000};
        state_d = lcgrb_pkg::ST_SCALE_TAKE;
      end
      lcgrb_pkg::ST_SCALE_TAKE: begin
        res_d   = is_byte_lim ? {8'h00, mac_p[15:8]} : mac_p[31:16];
        state_d = lcgrb_pkg::ST_DONE;
      end
      lcgrb_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = lcgrb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lcgrb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_d = out_load ? res_q : out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcgrb_pkg::ST_IDLE;
      seed_q      <= 16'h0000;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seed_q      <= seed_d;
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    lim_q      <= lim_d;
    pos_q      <= pos_d;
    hi_q       <= hi_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready_o = (state_q == lcgrb_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_eval_after_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcgrb_pkg::ST_EVAL) |-> ($past(state_q) == lcgrb_pkg::ST_DRAW))
    else $error("evaluate step without a preceding multiply-add");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == lcgrb_pkg::ST_DONE))
    else $error("output register loaded outside the final step");

  a_scale_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcgrb_pkg::ST_SCALE_TAKE) |->
      (cmd_q == lcgrb_pkg::CMD_BYTE_LIMITED || cmd_q == lcgrb_pkg::CMD_WORD_LIMITED))
    else $error("scaling step for a command without a limit");

  a_seed_only_on_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lcgrb_pkg::ST_EVAL) |=> $stable(seed_q))
    else $error("seed changed outside a draw");
`endif

endmodule

`default_nettype wire
